### rtl/core/sorted_array_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted array priority queue
// Same-cycle and next-cycle implications, sampled on the rising clock edge
// and switched off while synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SAPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sapq assertion failed (same cycle)");

// antecedent implies consequent in the next cycle
`define SAPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sapq assertion failed (next cycle)");

`endif

### rtl/core/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants of the sorted array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

  // field widths
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 6;
  localparam int FIDX_W    = 5;

  // defaults
  localparam int DEF_DEPTH = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // transaction operation codes
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_FIND    = 2'd2
  } action_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // search unit states
  typedef enum logic {
    SRCH_IDLE = 1'b0,
    SRCH_RUN  = 1'b1
  } srch_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     ins_en;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // search unit completion
  typedef struct packed {
    logic done;
    logic hit;
  } srch_res_t;

endpackage

### rtl/core/sorted_array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Priority queue of signed words kept in ascending order in a chain of
// cells; insert, dequeue of the largest entry and binary-search find.
// ----------------------------------------------------------------------------
//  channel   ports                                       handshake
//  input     in_action, in_value                         start / busy
//  result    out_status, out_value, out_found_index      out_strobe, one cycle
//  config    cfg_wr_data                                 cfg_wr_en
//
//  insert, dequeue and the unused code strobe their result in the next cycle
//  and busy stays low, so transactions may follow back to back.
//  find holds busy while it searches, one probe per cycle on the single
//  read port of the search unit; the result strobes as busy drops.
//  reset empties the queue and sets capacity to 32; stored words are not
//  cleared. the receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_unit_assert.svh"

module sorted_array_priority_queue_unit #(
  parameter int DEPTH = sapq_pkg::DEF_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input transaction
  input  logic                               start,
  output logic                               busy,
  input  logic [sapq_pkg::ACT_W-1:0]         in_action,
  input  logic signed [sapq_pkg::DATA_W-1:0] in_value,
  // result transaction
  output logic                               out_strobe,
  output logic [sapq_pkg::STAT_W-1:0]        out_status,
  output logic signed [sapq_pkg::DATA_W-1:0] out_value,
  output logic [sapq_pkg::FIDX_W-1:0]        out_found_index,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [sapq_pkg::CAP_W-1:0]         cfg_wr_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int LW = (CW > sapq_pkg::CAP_W) ? CW : sapq_pkg::CAP_W;
  localparam int FW = sapq_pkg::FIDX_W;

  logic [CW-1:0]                      count_r;
  logic [sapq_pkg::CAP_W-1:0]         cap_r;
  logic                               strobe_r;
  logic [sapq_pkg::STAT_W-1:0]        status_r;
  logic signed [sapq_pkg::DATA_W-1:0] value_r;
  logic [FW-1:0]                      fidx_r;

  logic                               accept;
  logic                               full;
  logic                               empty;
  sapq_pkg::cell_ctrl_t               ctrl;
  logic signed [sapq_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH:0]                     lt_chain;
  logic [IW-1:0]                      srch_idx;
  logic [IW-1:0]                      rd_idx;
  logic [CW-1:0]                      last_idx;
  logic signed [sapq_pkg::DATA_W-1:0] rd_data;
  logic                               srch_busy;
  sapq_pkg::srch_res_t                srch_res;
  logic                               launch;
  logic [FW+IW-1:0]                   fidx_wide;

  assign accept = start && !busy;
  assign busy   = srch_busy;
  assign empty  = (count_r == '0);
  assign full   = (LW'(count_r) >= LW'(cap_r)) || (count_r >= CW'(DEPTH));
  assign launch = accept && (in_action == sapq_pkg::ACT_FIND);

  // insert broadcast to the cell chain
  assign ctrl.ins_en = accept && (in_action == sapq_pkg::ACT_INSERT) && !full;
  assign ctrl.value  = in_value;

  // cell chain: boundary below cell zero counts as smaller than any value
  assign lt_chain[0] = 1'b1;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sapq_pkg::DATA_W-1:0] prev_data;
    if (i == 0) begin : g_first
      assign prev_data = ctrl.value;
    end else begin : g_rest
      assign prev_data = cell_data[i-1];
    end
    sapq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (count_r > CW'(i)),
      .prev_lt   (lt_chain[i]),
      .prev_data (prev_data),
      .data_o    (cell_data[i]),
      .lt_o      (lt_chain[i+1])
    );
  end

  // single read port shared by dequeue and search probes
  assign last_idx = count_r - 1'b1;
  assign rd_idx   = srch_busy ? srch_idx : last_idx[IW-1:0];
  assign rd_data  = cell_data[rd_idx];

  sapq_search #(
    .DEPTH (DEPTH)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .launch  (launch),
    .value   (in_value),
    .count   (count_r),
    .rd_idx  (srch_idx),
    .rd_data (rd_data),
    .busy    (srch_busy),
    .res     (srch_res)
  );

  assign fidx_wide = {{FW{1'b0}}, srch_idx};

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sapq_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.ins_en) begin
      count_r <= count_r + 1'b1;
    end else if (accept && (in_action == sapq_pkg::ACT_DEQUEUE) && !empty) begin
      count_r <= count_r - 1'b1;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (accept && !launch) || srch_res.done;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fidx_r <= '0;
      unique case (in_action)
        sapq_pkg::ACT_INSERT: begin
          status_r <= full ? sapq_pkg::ST_FULL : sapq_pkg::ST_OK;
          value_r  <= '0;
        end
        sapq_pkg::ACT_DEQUEUE: begin
          status_r <= empty ? sapq_pkg::ST_EMPTY : sapq_pkg::ST_OK;
          value_r  <= empty ? '0 : rd_data;
        end
        // find answers later, the unused code answers ok with zeros
        default: begin
          status_r <= sapq_pkg::ST_OK;
          value_r  <= '0;
        end
      endcase
    end else if (srch_res.done) begin
      status_r <= srch_res.hit ? sapq_pkg::ST_OK : sapq_pkg::ST_NOT_FOUND;
      value_r  <= '0;
      fidx_r   <= srch_res.hit ? fidx_wide[FW-1:0] : '0;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_value       = value_r;
  assign out_found_index = fidx_r;

  // checks
  `SAPQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `SAPQ_ASSERT_NEXT(a_accept_answers, clk, rst_n, accept, out_strobe || busy)
  `SAPQ_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `SAPQ_ASSERT_NEXT(a_full_holds_count, clk, rst_n,
    accept && (in_action == sapq_pkg::ACT_INSERT) && full, $stable(count_r))

endmodule

### rtl/core/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// One storage cell of the sorted chain. Compares its entry with the
// broadcast value and, on insert, keeps its entry, takes the new value or
// takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module sapq_cell (
  input  logic                               clk,
  input  sapq_pkg::cell_ctrl_t               ctrl,
  input  logic                               valid,
  input  logic                               prev_lt,
  input  logic signed [sapq_pkg::DATA_W-1:0] prev_data,
  output logic signed [sapq_pkg::DATA_W-1:0] data_o,
  output logic                               lt_o
);

  logic signed [sapq_pkg::DATA_W-1:0] data_r;

  // stored entry is smaller than the broadcast value
  assign lt_o   = valid && (data_r < ctrl.value);
  assign data_o = data_r;

  // insert: cells at or above the slot shift up, the slot takes the value
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !lt_o) begin
      data_r <= prev_lt ? ctrl.value : prev_data;
    end
  end

endmodule

### rtl/core/sapq_search.sv
// ----------------------------------------------------------------------------
// sapq_search
// Iterative binary search over the sorted chain, one probe per cycle
// through a single read port, midpoint lo + (hi - 1 - lo) / 2.
// ----------------------------------------------------------------------------
module sapq_search #(
  parameter int DEPTH = sapq_pkg::DEF_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               launch,
  input  logic signed [sapq_pkg::DATA_W-1:0] value,
  input  logic [$clog2(DEPTH+1)-1:0]         count,
  output logic [$clog2(DEPTH)-1:0]           rd_idx,
  input  logic signed [sapq_pkg::DATA_W-1:0] rd_data,
  output logic                               busy,
  output sapq_pkg::srch_res_t                res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  sapq_pkg::srch_state_t              state_r, state_nxt;
  logic [CW-1:0]                      lo_r, hi_r;
  logic signed [sapq_pkg::DATA_W-1:0] val_r;
  logic [CW-1:0]                      span;
  logic [CW-1:0]                      mid;
  logic                               empty_range;
  logic                               eq;
  logic                               less;

  // probe address
  assign empty_range = (lo_r >= hi_r);
  assign span        = hi_r - lo_r - 1'b1;
  assign mid         = lo_r + (span >> 1);
  assign rd_idx      = mid[IW-1:0];
  assign eq          = (rd_data == val_r);
  assign less        = (rd_data < val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sapq_pkg::SRCH_IDLE: begin
        if (launch) state_nxt = sapq_pkg::SRCH_RUN;
      end
      sapq_pkg::SRCH_RUN: begin
        if (empty_range || eq) state_nxt = sapq_pkg::SRCH_IDLE;
      end
      default: state_nxt = sapq_pkg::SRCH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b0;
    res.done = 1'b0;
    res.hit  = 1'b0;
    unique case (state_r)
      sapq_pkg::SRCH_IDLE: begin
        busy = 1'b0;
      end
      sapq_pkg::SRCH_RUN: begin
        busy     = 1'b1;
        res.done = empty_range || eq;
        res.hit  = !empty_range && eq;
      end
      default: busy = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapq_pkg::SRCH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // search window
  always_ff @(posedge clk) begin
    if (state_r == sapq_pkg::SRCH_IDLE && launch) begin
      lo_r  <= '0;
      hi_r  <= count;
      val_r <= value;
    end else if (state_r == sapq_pkg::SRCH_RUN && !empty_range && !eq) begin
      if (less) begin
        lo_r <= mid + 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
  end

endmodule
